@@ sv/nfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared types and constants for the nearest free slot assigner.
// ----------------------------------------------------------------------------
package nfsa_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned IDX_W     = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned CAP_W     = 17;
  localparam int unsigned DIST_W    = COORD_W + 1;
  localparam logic [CAP_W-1:0] COUNT_MAX = {CAP_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_PLACE  = 2'd1,
    OP_REPORT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT,
    ST_DRAIN,
    ST_UPDATE
  } st_e;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [IDX_W-1:0]          slot_index;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [CAP_W-1:0]          capacity;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_slot;
    logic [CAP_W-1:0] slot_count;
    logic             no_space;
    logic             last;
  } res_t;

  // one table entry as read out
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CAP_W-1:0]          cap;
    logic [CAP_W-1:0]          used;
    logic                      full;
  } slot_rec_t;

  // table write requests: slot load and count update
  typedef struct packed {
    logic                      ld_en;
    logic [IDX_W-1:0]          ld_idx;
    logic signed [COORD_W-1:0] ld_x;
    logic signed [COORD_W-1:0] ld_y;
    logic [CAP_W-1:0]          ld_cap;
    logic                      up_en;
    logic [IDX_W-1:0]          up_idx;
    logic [CAP_W-1:0]          up_used;
    logic                      up_full;
  } tbl_wr_t;

  // sequencer controls
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             cmp_clear;
    logic             scan_vld;
    logic             rpt_vld;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_last;
    logic             upd;
  } seq_ctl_t;

  // running best candidate of a place scan
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [CAP_W-1:0] used;
    logic [CAP_W-1:0] cap;
  } best_t;

endpackage

@@ sv/nfsa_table.sv @@
// ----------------------------------------------------------------------------
// nfsa_table
// Slot storage: position and capacity in memory, counts and full flags in
// reset flops; one registered read port.
// ----------------------------------------------------------------------------
module nfsa_table
  import nfsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_wr_t          wr_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output slot_rec_t        rd_o
);

  logic signed [COORD_W-1:0] mem_x [NUM_SLOTS];
  logic signed [COORD_W-1:0] mem_y [NUM_SLOTS];
  logic [CAP_W-1:0]          mem_cap [NUM_SLOTS];
  logic [CAP_W-1:0]          used_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]      full_q;
  slot_rec_t                 rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.ld_en) begin
      mem_x[wr_i.ld_idx]   <= wr_i.ld_x;
      mem_y[wr_i.ld_idx]   <= wr_i.ld_y;
      mem_cap[wr_i.ld_idx] <= wr_i.ld_cap;
    end
    if (rd_en_i) begin
      rd_q.x    <= mem_x[rd_addr_i];
      rd_q.y    <= mem_y[rd_addr_i];
      rd_q.cap  <= mem_cap[rd_addr_i];
      rd_q.used <= used_q[rd_addr_i];
      rd_q.full <= full_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        used_q[i] <= '0;
      end
      full_q <= '0;
    end else begin
      if (wr_i.ld_en) begin
        used_q[wr_i.ld_idx] <= '0;
        full_q[wr_i.ld_idx] <= (wr_i.ld_cap == '0);
      end else if (wr_i.up_en) begin
        used_q[wr_i.up_idx] <= wr_i.up_used;
        full_q[wr_i.up_idx] <= wr_i.up_full;
      end
    end
  end

  assign rd_o = rd_q;

endmodule

@@ sv/nfsa_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// nfsa_cmp_unit
// Shared distance and compare unit: takes one slot per cycle while en_i is
// high and keeps the best free slot seen so far.
// ----------------------------------------------------------------------------
module nfsa_cmp_unit
  import nfsa_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      en_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  slot_rec_t                 slot_i,
  input  logic signed [COORD_W-1:0] rx_i,
  input  logic signed [COORD_W-1:0] ry_i,
  output best_t                     best_o
);

  logic signed [COORD_W:0]   dx, dy;
  logic [DIST_W-1:0]         adx, ady, mdist;
  logic                      take;
  logic                      found_q;
  logic [IDX_W-1:0]          idx_q;
  logic [DIST_W-1:0]         dist_q;
  logic signed [COORD_W-1:0] bx_q, by_q;
  logic [CAP_W-1:0]          used_q, cap_q;

  assign dx    = {slot_i.x[COORD_W-1], slot_i.x} - {rx_i[COORD_W-1], rx_i};
  assign dy    = {slot_i.y[COORD_W-1], slot_i.y} - {ry_i[COORD_W-1], ry_i};
  assign adx   = dx[COORD_W] ? DIST_W'(-dx) : DIST_W'(dx);
  assign ady   = dy[COORD_W] ? DIST_W'(-dy) : DIST_W'(dy);
  assign mdist = adx + ady;

  // distance, then smaller x, then smaller y; equal keeps the lower index
  always_comb begin
    take = 1'b0;
    if (en_i && !slot_i.full) begin
      priority if (!found_q)        take = 1'b1;
      else if (mdist != dist_q)     take = (mdist < dist_q);
      else if (slot_i.x != bx_q)    take = (slot_i.x < bx_q);
      else                          take = (slot_i.y < by_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clear_i) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !clear_i) begin
      idx_q  <= idx_i;
      dist_q <= mdist;
      bx_q   <= slot_i.x;
      by_q   <= slot_i.y;
      used_q <= slot_i.used;
      cap_q  <= slot_i.cap;
    end
  end

  assign best_o.found = found_q;
  assign best_o.idx   = idx_q;
  assign best_o.used  = used_q;
  assign best_o.cap   = cap_q;

endmodule

@@ sv/nfsa_seq.sv @@
// ----------------------------------------------------------------------------
// nfsa_seq
// Sequencer: walks the slot index for place scans and reports, tracks the
// registered read pipeline and issues the count update.
// ----------------------------------------------------------------------------
module nfsa_seq
  import nfsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       opcode_i,
  input  logic [CNT_W-1:0] n_i,
  output logic             busy_o,
  output seq_ctl_t         ctl_o
);

  st_e              st_q, st_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             rpt_q, rpt_d;
  logic             rd_vld_q, rd_rpt_q, rd_last_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_en, cmp_clear, upd, at_end;

  assign at_end = ((idx_q + CNT_W'(1)) == n_i);

  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    rpt_d     = rpt_q;
    rd_en     = 1'b0;
    cmp_clear = 1'b0;
    upd       = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept_i && (opcode_i == OP_PLACE)) begin
          cmp_clear = 1'b1;
          rpt_d     = 1'b0;
          st_d      = (n_i == '0) ? ST_UPDATE : ST_SCAN;
        end else if (accept_i && (opcode_i == OP_REPORT) && (n_i != '0)) begin
          rpt_d = 1'b1;
          st_d  = ST_REPORT;
        end
      end
      ST_SCAN, ST_REPORT: begin
        rd_en = 1'b1;
        idx_d = idx_q + CNT_W'(1);
        if (at_end) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        st_d = rpt_q ? ST_IDLE : ST_UPDATE;
      end
      ST_UPDATE: begin
        upd  = 1'b1;
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      idx_q    <= '0;
      rpt_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      rpt_q    <= rpt_d;
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= idx_q[IDX_W-1:0];
    rd_rpt_q  <= rpt_q;
    rd_last_q <= at_end;
  end

  assign busy_o          = (st_q != ST_IDLE);
  assign ctl_o.rd_en     = rd_en;
  assign ctl_o.rd_addr   = idx_q[IDX_W-1:0];
  assign ctl_o.cmp_clear = cmp_clear;
  assign ctl_o.scan_vld  = rd_vld_q && !rd_rpt_q;
  assign ctl_o.rpt_vld   = rd_vld_q && rd_rpt_q;
  assign ctl_o.rd_idx    = rd_idx_q;
  assign ctl_o.rd_last   = rd_last_q;
  assign ctl_o.upd       = upd;

endmodule

@@ sv/nearest_free_slot_assigner.sv @@
// ----------------------------------------------------------------------------
// nearest_free_slot_assigner
// Slot table with nearest-free-slot placement by Manhattan distance, slot
// loading and count reports; one compare unit scans the slots in turn.
// ----------------------------------------------------------------------------
// Place: busy through n slot reads, one drain and one update step; the result
//   is registered from the update step; n = active slots, n of 0 skips the scan.
// Report: busy through n slot reads and the drain step, n strobes back to back.
// Load: never busy. One slot per cycle through the single read port
//   and compare unit sets the scan length.
// Reset: counts, full flags, slots_in_use and control clear; results cannot stall.
// ----------------------------------------------------------------------------
module nearest_free_slot_assigner
  import nfsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // command channel
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd_i,
  // result channel: one-cycle strobe
  output logic             result_valid_o,
  output res_t             result_o,
  // configuration: slots_in_use
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  logic                      accept;
  logic [CNT_W-1:0]          cfg_q;
  logic [CNT_W-1:0]          n_act;
  logic signed [COORD_W-1:0] rx_q, ry_q;
  seq_ctl_t                  ctl;
  slot_rec_t                 rd;
  best_t                     best;
  tbl_wr_t                   wr;
  logic [CAP_W-1:0]          new_used;
  logic                      res_vld_q, res_vld_d;
  res_t                      res_q, res_d;

  // a transaction is taken when start is high and the sequencer is idle
  assign accept      = start && !busy;
  // config waits for the sequencer and never lands together with a command
  assign cfg_ready_o = !busy && !start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // active slots: the register value, held to the table size
  assign n_act = (cfg_q > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : cfg_q;

  // requester position, held for the whole scan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rx_q <= cmd_i.x_coord;
      ry_q <= cmd_i.y_coord;
    end
  end

  nfsa_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (cmd_i.opcode),
    .n_i      (n_act),
    .busy_o   (busy),
    .ctl_o    (ctl)
  );

  // Count update of the chosen slot: saturating bump, full on reaching
  // capacity. The chosen slot was free, so the flag is simply recomputed.
  assign new_used = (best.used < COUNT_MAX) ? best.used + CAP_W'(1) : best.used;

  // Load writes at the accepting edge (every 4-bit index is a table slot);
  // the update writes in the sequencer's update step. They never coincide.
  always_comb begin
    wr.ld_en   = accept && (cmd_i.opcode == OP_LOAD);
    wr.ld_idx  = cmd_i.slot_index;
    wr.ld_x    = cmd_i.x_coord;
    wr.ld_y    = cmd_i.y_coord;
    wr.ld_cap  = cmd_i.capacity;
    wr.up_en   = ctl.upd && best.found;
    wr.up_idx  = best.idx;
    wr.up_used = new_used;
    wr.up_full = (new_used == best.cap);
  end

  nfsa_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_en_i   (ctl.rd_en),
    .rd_addr_i (ctl.rd_addr),
    .rd_o      (rd)
  );

  nfsa_cmp_unit u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (ctl.cmp_clear),
    .en_i    (ctl.scan_vld),
    .idx_i   (ctl.rd_idx),
    .slot_i  (rd),
    .rx_i    (rx_q),
    .ry_i    (ry_q),
    .best_o  (best)
  );

  // Result register: report results stream straight from the read data;
  // a place result comes from the update step, or flags no_space when no
  // free slot was seen.
  always_comb begin
    res_vld_d = 1'b0;
    res_d     = res_q;
    if (ctl.upd) begin
      res_vld_d = 1'b1;
      if (best.found) begin
        res_d.chosen_slot = best.idx;
        res_d.slot_count  = new_used;
        res_d.no_space    = 1'b0;
      end else begin
        res_d.chosen_slot = '0;
        res_d.slot_count  = '0;
        res_d.no_space    = 1'b1;
      end
      res_d.last = 1'b1;
    end else if (ctl.rpt_vld) begin
      res_vld_d         = 1'b1;
      res_d.chosen_slot = ctl.rd_idx;
      res_d.slot_count  = rd.used;
      res_d.no_space    = 1'b0;
      res_d.last        = ctl.rd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

`ifndef ASSERT_OFF
  // report results arrive back to back until the last one
  a_rpt_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o)
    else $error("report stream broke before last");

  // no_space only on a final place result with a zero count
  a_nospace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.no_space |->
      result_o.last && (result_o.slot_count == '0))
    else $error("bad no_space result");

  // the update step ends the place transaction
  a_upd_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.upd |=> !busy && result_valid_o && result_o.last)
    else $error("place did not finish after update");

  // a load never makes the block busy
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i.opcode == OP_LOAD) |=> !busy && !result_valid_o)
    else $error("load raised busy or a result");
`endif

endmodule
